FILE: hw/rtl/akrt_pkg.sv
// ----------------------------------------------------------------------------
// akrt_pkg: shared types and constants for the analog key rapid trigger
// Key table layout, request formats, command codes and field widths.
// ----------------------------------------------------------------------------
package akrt_pkg;

  localparam int NUM_KEYS    = 16;
  localparam int SAMPLE_BITS = 16;

  localparam int KEY_W      = 4;
  localparam int VAL_W      = 16;
  localparam int HYST_W     = 12;
  localparam int MEM_DEPTH  = 1 << KEY_W;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 24;

  localparam logic [HYST_W-1:0] HYST_RESET = HYST_W'(10);
  localparam logic [VAL_W-1:0]  VAL_MASK   = VAL_W'((1 << SAMPLE_BITS) - 1);

  // Register index, taken from paddr[2].
  localparam logic REG_HYST = 1'b0;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_SET    = 1'b1
  } cmd_t;

  typedef struct packed {
    logic             pressed;
    logic [VAL_W-1:0] low;
    logic [VAL_W-1:0] rapid;
    logic [VAL_W-1:0] trigger;
  } entry_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] sample;
    logic [VAL_W-1:0] trig;
    logic [VAL_W-1:0] rapid;
  } item_t;

  typedef struct packed {
    logic             rd_en;
    logic [KEY_W-1:0] rd_key;
    logic             wr_en;
    logic [KEY_W-1:0] wr_key;
    entry_t           wr_data;
  } mem_req_t;

endpackage

FILE: hw/rtl/akrt_cfg.sv
// ----------------------------------------------------------------------------
// akrt_cfg: configuration register file
// APB-style slave holding the hysteresis register.
// ----------------------------------------------------------------------------
module akrt_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [akrt_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [akrt_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [akrt_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output logic [akrt_pkg::HYST_W-1:0]     hyst
);
  import akrt_pkg::*;

  logic [HYST_W-1:0] hyst_r;
  logic [HYST_W-1:0] hyst_nxt;
  logic              hit;

  assign hit    = (paddr[2] == REG_HYST);
  assign pready = 1'b1;
  assign hyst   = hyst_r;
  assign prdata = hit ? CFG_DATA_W'(hyst_r) : '0;

  always_comb begin
    hyst_nxt = hyst_r;
    if (psel && penable && pwrite && pready && hit) begin
      hyst_nxt = pwdata[HYST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hyst_r <= HYST_RESET;
    end else begin
      hyst_r <= hyst_nxt;
    end
  end

endmodule

FILE: hw/rtl/akrt_mem.sv
// ----------------------------------------------------------------------------
// akrt_mem: per-key state memory
// Synchronous RAM with one read and one write port, read data registered.
// Per-entry valid bits make unwritten keys read as all zero after reset.
// ----------------------------------------------------------------------------
module akrt_mem (
  input  logic               clk,
  input  logic               rst_n,
  input  akrt_pkg::mem_req_t req,
  output akrt_pkg::entry_t   rd_data
);
  import akrt_pkg::*;

  entry_t                 mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0]   valid_r;
  logic [MEM_DEPTH-1:0]   valid_nxt;
  entry_t                 rd_entry_r;
  logic                   rd_valid_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_key] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_entry_r <= mem[req.rd_key];
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (req.wr_en) begin
      valid_nxt[req.wr_key] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (req.rd_en) begin
        rd_valid_r <= valid_r[req.rd_key];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_entry_r : '0;

endmodule

FILE: hw/rtl/akrt_eval.sv
// ----------------------------------------------------------------------------
// akrt_eval: key update logic
// Computes a key's new state from its stored entry and one request.
// ----------------------------------------------------------------------------
module akrt_eval (
  input  akrt_pkg::item_t             item,
  input  akrt_pkg::entry_t            entry_in,
  input  logic [akrt_pkg::HYST_W-1:0] hyst,
  output akrt_pkg::entry_t            entry_out,
  output logic                        key_ok
);
  import akrt_pkg::*;

  logic [VAL_W-1:0] val;
  logic [VAL_W-1:0] trig;
  logic [VAL_W-1:0] rapid;
  logic [VAL_W:0]   val_h;
  logic [VAL_W+1:0] rel_lim;
  logic             in_region;
  logic             new_low;
  logic             release_hit;
  logic [VAL_W-1:0] mark;

  assign val   = item.sample & VAL_MASK;
  assign trig  = item.trig & VAL_MASK;
  assign rapid = item.rapid & VAL_MASK;

  assign key_ok = (int'(item.key) < NUM_KEYS);

  // Comparisons against (level - hysteresis) are done by moving the
  // hysteresis to the sample side, so nothing goes negative.
  assign val_h     = {1'b0, val} + {{(VAL_W + 1 - HYST_W){1'b0}}, hyst};
  assign in_region = (val_h < {1'b0, entry_in.trigger});
  assign new_low   = (val_h < {1'b0, entry_in.low});
  assign rel_lim   = {2'b0, entry_in.low} + {{(VAL_W + 2 - HYST_W){1'b0}}, hyst}
                   + {2'b0, entry_in.rapid};
  assign release_hit = ({2'b0, val} > rel_lim);
  assign mark      = (val >= entry_in.rapid) ? (val - entry_in.rapid) : '0;

  always_comb begin
    entry_out = entry_in;
    case (item.cmd)
      CMD_SET: begin
        entry_out.trigger = trig;
        entry_out.rapid   = rapid;
        entry_out.low     = trig;
        entry_out.pressed = 1'b0;
      end
      CMD_SAMPLE: begin
        if (entry_in.trigger != '0) begin
          if (in_region) begin
            if (new_low) begin
              entry_out.low     = val;
              entry_out.pressed = 1'b1;
            end else if (release_hit) begin
              entry_out.low     = mark;
              entry_out.pressed = 1'b0;
            end
          end else begin
            entry_out.pressed = 1'b0;
          end
        end
      end
      default: begin
        entry_out = entry_in;
      end
    endcase
  end

endmodule

FILE: hw/rtl/analog_key_rapid_trigger.sv
// ----------------------------------------------------------------------------
// analog_key_rapid_trigger: per-key actuation for analog keyswitches
// Rapid-trigger press/release tracking for up to sixteen hall effect keys.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Signals                        Contents
//   in_      in   tvalid/tready/tdata/tuser      set or sample request
//   out_     out  tvalid/tready/tdata            key, pressed flag, low mark
//   cfg_     in   psel/penable/pwrite/paddr/...  hysteresis register
//
// One request is taken per clock cycle unless a stalled output holds the
// input back. Its key's entry is read from the state memory at the accepting
// edge and updated in the cycle that follows. The updated entry is written
// back at the edge where the update stage advances, the same edge that loads
// the output register. Back-to-back requests to the same key are
// served by forwarding the entry that was just written, since the memory
// returns the old contents on a read that coincides with a write.
// Reset is synchronous and clears the per-key valid bits at once, so every
// key reads as disabled with no clearing pass. A stalled output holds the
// result and the request behind it; input ready drops only while both are full.
//
module analog_key_rapid_trigger (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input requests.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // tdata, from bit 0: key[3:0], sample[19:4], trigger_level[35:20],
  // release_dist[51:36], zero fill[55:52].
  input  logic [akrt_pkg::IN_DATA_W-1:0]  in_tdata,
  // tuser: cmd (0 = sample, 1 = load key settings).
  input  logic                           in_tuser,
  // Results.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // tdata, from bit 0: key_out[3:0], pressed[4], low_mark[20:5],
  // zero fill[23:21].
  output logic [akrt_pkg::OUT_DATA_W-1:0] out_tdata,
  // Configuration.
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [akrt_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [akrt_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [akrt_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import akrt_pkg::*;

  logic [HYST_W-1:0] hyst;
  item_t             in_item;
  logic              in_acc;

  // Update stage.
  logic              s1_valid_r;
  logic              s1_valid_nxt;
  item_t             s1_item_r;
  logic              s1_fire;

  // Forwarding of the last written entry.
  logic              fwd_valid_r;
  logic [KEY_W-1:0]  fwd_key_r;
  entry_t            fwd_entry_r;

  // Output register.
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [KEY_W-1:0]  out_key_r;
  logic              out_pressed_r;
  logic [VAL_W-1:0]  out_low_r;

  mem_req_t          mem_req;
  entry_t            mem_rd;
  entry_t            entry_in;
  entry_t            entry_out;
  logic              key_ok;

  akrt_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .hyst    (hyst)
  );

  assign in_item.cmd    = cmd_t'(in_tuser);
  assign in_item.key    = in_tdata[3:0];
  assign in_item.sample = in_tdata[19:4];
  assign in_item.trig   = in_tdata[35:20];
  assign in_item.rapid  = in_tdata[51:36];

  // The update stage advances whenever the output register is free or drains.
  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_acc    = in_tvalid && in_tready;

  // A key written at the edge where this request's read happened comes from
  // the forwarding register instead of the memory.
  assign entry_in = (fwd_valid_r && (fwd_key_r == s1_item_r.key)) ? fwd_entry_r : mem_rd;

  akrt_eval u_eval (
    .item      (s1_item_r),
    .entry_in  (entry_in),
    .hyst      (hyst),
    .entry_out (entry_out),
    .key_ok    (key_ok)
  );

  assign mem_req.rd_en   = in_acc;
  assign mem_req.rd_key  = in_item.key;
  assign mem_req.wr_en   = s1_fire && key_ok;
  assign mem_req.wr_key  = s1_item_r.key;
  assign mem_req.wr_data = entry_out;

  akrt_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (mem_rd)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (mem_req.wr_en) begin
        fwd_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_item;
    end
    if (mem_req.wr_en) begin
      fwd_key_r   <= mem_req.wr_key;
      fwd_entry_r <= entry_out;
    end
    if (s1_fire) begin
      out_key_r     <= s1_item_r.key;
      out_pressed_r <= key_ok ? entry_out.pressed : 1'b0;
      out_low_r     <= key_ok ? entry_out.low : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - VAL_W - 1 - KEY_W){1'b0}},
                       out_low_r, out_pressed_r, out_key_r};

endmodule
